// File: sv/rs485ftx_pkg.sv
`default_nettype none

package rs485ftx_pkg;

   // frame store depth default
   localparam int FRAME_BYTES_DEF = 512;

   // field widths
   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int FILL_W   = 4;

   // reset value of the postdrive filler count
   localparam logic [FILL_W-1:0] POSTDRIVE_RESET = 4'd2;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
   localparam logic [OP_W-1:0] OP_START     = 2'd1;
   localparam logic [OP_W-1:0] OP_CHAR_DONE = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_FILL = 2'd2,
      PH_WAIT = 2'd3
   } phase_type;

   // per-item result from the sequencer to the output stage
   typedef struct packed {
      logic      tx_valid;
      logic      use_mem;
      logic      driver_enable;
      logic      receiver_enable;
      logic      frame_done;
      phase_type phase;
   } result_type;

endpackage

`default_nettype wire

// File: sv/rs485ftx_store.sv
`default_nettype none

module rs485ftx_store #(
   parameter int FRAME_BYTES = rs485ftx_pkg::FRAME_BYTES_DEF,
   localparam int AW = $clog2(FRAME_BYTES)
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [rs485ftx_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                           rd_en,
   input  wire logic [AW-1:0]                  rd_addr,
   output logic      [rs485ftx_pkg::BYTE_W-1:0] rd_data
);

   logic [rs485ftx_pkg::BYTE_W-1:0] mem_ff [FRAME_BYTES];
   logic [rs485ftx_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data held while the result waits
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/rs485ftx_ctrl.sv
`default_nettype none

module rs485ftx_ctrl #(
   parameter int FRAME_BYTES = rs485ftx_pkg::FRAME_BYTES_DEF,
   localparam int AW = $clog2(FRAME_BYTES),
   localparam int LW = $clog2(FRAME_BYTES + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [rs485ftx_pkg::FILL_W-1:0]  csr_wr_data,
   input  wire logic                             item_fire,
   input  wire logic [rs485ftx_pkg::OP_W-1:0]    item_op,
   input  wire logic                             item_first,
   input  wire logic                             item_last,
   output rs485ftx_pkg::result_type              result,
   output logic                                  wr_en,
   output logic      [AW-1:0]                    wr_addr,
   output logic      [AW-1:0]                    rd_addr
);

   logic [rs485ftx_pkg::FILL_W-1:0] postdrive_ff, postdrive_in;
   logic [LW-1:0]                   len_ff, len_in;
   logic [LW-1:0]                   idx_ff, idx_in;
   rs485ftx_pkg::phase_type         phase_ff, phase_in;
   logic                            pending_ff, pending_in;
   logic [rs485ftx_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic                            drv_ff, drv_in;

   logic [LW-1:0] len_base;
   logic [LW-1:0] idx_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         postdrive_ff <= rs485ftx_pkg::POSTDRIVE_RESET;
         len_ff       <= '0;
         idx_ff       <= '0;
         phase_ff     <= rs485ftx_pkg::PH_IDLE;
         pending_ff   <= 1'b0;
         fill_ff      <= '0;
         drv_ff       <= 1'b0;
      end else begin
         postdrive_ff <= postdrive_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         fill_ff      <= fill_in;
         drv_ff       <= drv_in;
      end
   end

   assign postdrive_in = csr_wr_en ? csr_wr_data : postdrive_ff;

   always_comb begin
      len_in     = len_ff;
      idx_in     = idx_ff;
      phase_in   = phase_ff;
      pending_in = pending_ff;
      fill_in    = fill_ff;
      drv_in     = drv_ff;
      wr_en      = 1'b0;
      wr_addr    = len_ff[AW-1:0];
      rd_addr    = '0;
      len_base   = item_first ? '0 : len_ff;
      idx_next   = idx_ff + LW'(1);
      result     = '0;

      if (item_fire) begin
         case (item_op)
            rs485ftx_pkg::OP_LOAD: begin
               // a first byte aborts data and completion phases, not filler
               if (item_first && (phase_ff == rs485ftx_pkg::PH_DATA ||
                                  phase_ff == rs485ftx_pkg::PH_WAIT)) begin
                  phase_in = rs485ftx_pkg::PH_IDLE;
               end
               len_in  = len_base;
               wr_addr = len_base[AW-1:0];
               if (len_base < LW'(FRAME_BYTES)) begin
                  wr_en  = 1'b1;
                  len_in = len_base + LW'(1);
               end
               if (item_last) begin
                  pending_in = 1'b1;
               end
            end
            rs485ftx_pkg::OP_START: begin
               if (pending_ff && phase_ff == rs485ftx_pkg::PH_IDLE) begin
                  drv_in          = 1'b1;
                  phase_in        = rs485ftx_pkg::PH_DATA;
                  idx_in          = '0;
                  pending_in      = 1'b0;
                  result.tx_valid = 1'b1;
                  result.use_mem  = 1'b1;
                  rd_addr         = '0;
               end
            end
            rs485ftx_pkg::OP_CHAR_DONE: begin
               case (phase_ff)
                  rs485ftx_pkg::PH_DATA: begin
                     idx_in = idx_next;
                     if (idx_next < len_ff) begin
                        result.tx_valid = 1'b1;
                        result.use_mem  = 1'b1;
                        rd_addr         = idx_next[AW-1:0];
                     end else begin
                        // release the driver, first zero filler goes out now
                        drv_in          = 1'b0;
                        fill_in         = postdrive_ff;
                        phase_in        = rs485ftx_pkg::PH_FILL;
                        result.tx_valid = 1'b1;
                     end
                  end
                  rs485ftx_pkg::PH_FILL: begin
                     if (fill_ff != '0) begin
                        fill_in         = fill_ff - rs485ftx_pkg::FILL_W'(1);
                        result.tx_valid = 1'b1;
                        if (fill_ff == rs485ftx_pkg::FILL_W'(1)) begin
                           phase_in = rs485ftx_pkg::PH_WAIT;
                        end
                     end else begin
                        phase_in = rs485ftx_pkg::PH_WAIT;
                     end
                  end
                  rs485ftx_pkg::PH_WAIT: begin
                     phase_in          = rs485ftx_pkg::PH_IDLE;
                     result.frame_done = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      result.driver_enable   = drv_in;
      result.receiver_enable = (phase_in == rs485ftx_pkg::PH_IDLE) && !drv_in;
      result.phase           = phase_in;
   end

   // driver is always released before filler and completion
   a_drv_off_late : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rs485ftx_pkg::PH_FILL || phase_ff == rs485ftx_pkg::PH_WAIT) |-> !drv_ff)
      else $error("driver on during filler or completion");

   // while sending, the index stays inside the loaded frame
   a_idx_in_frame : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rs485ftx_pkg::PH_DATA) |-> (idx_ff < len_ff))
      else $error("send index beyond frame length");

   // the driver only comes on from idle with a start pending
   a_drv_rise : assert property (@(posedge clock) disable iff (reset)
      $rose(drv_ff) |-> ($past(phase_ff) == rs485ftx_pkg::PH_IDLE && $past(pending_ff)))
      else $error("driver enabled without a pending start");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(FRAME_BYTES))
      else $error("frame length exceeds store size");

endmodule

`default_nettype wire

// File: sv/rs485_frame_transmit_sequencer_core.sv
// RS-485 half-duplex frame transmit sequencer. Each req transfer carries one
// operation in req_tuser[1:0]: load a frame byte (req_tdata, first byte flag in
// req_tuser[2], last byte flag on req_tlast), poll for start, or report that
// the UART finished a character. Every req transfer yields exactly one rsp
// transfer telling whether a character is to be sent (rsp_tuser), which byte,
// the line driver and receiver enable levels, a completion flag and the
// current phase. The block takes one transfer per clock while rsp_tready keeps
// the result register draining. An accepted item waits in the input register
// and then moves into the result register once that is free or draining, so
// its result is offered on rsp from there; the byte read from the frame store
// is latched alongside the result by the store's registered read port.
// While rsp_tready is low the two registers hold two items and req_tready
// drops until the result register drains. The frame store has no reset and
// is not cleared; a start always follows at least one loaded byte. The
// postdrive filler count (csr_wr_data, reset 2) is written through
// csr_wr_en and should only be changed while no transfer is in flight.

`default_nettype none

module rs485_frame_transmit_sequencer_core #(
   parameter int FRAME_BYTES = rs485ftx_pkg::FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,   // postdrive_chars

   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // data[7:0]
   input  wire logic [2:0]  req_tuser,     // op[1:0], first[2]
   input  wire logic        req_tlast,     // last

   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,     // tx_byte[7:0], driver_enable[8],
                                           // receiver_enable[9], frame_done[10],
                                           // phase[12:11], zero pad[15:13]
   output logic             rsp_tuser      // tx_valid
);

   localparam int AW = $clog2(FRAME_BYTES);

   // input register
   logic                              in_valid_ff, in_valid_in;
   logic [rs485ftx_pkg::OP_W-1:0]     in_op_ff;
   logic [rs485ftx_pkg::BYTE_W-1:0]   in_data_ff;
   logic                              in_first_ff;
   logic                              in_last_ff;

   // result register
   logic                              out_valid_ff, out_valid_in;
   rs485ftx_pkg::result_type          out_res_ff;

   rs485ftx_pkg::result_type          result;
   logic                              fire;
   logic                              accept;
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic [AW-1:0]                     rd_addr;
   logic [rs485ftx_pkg::BYTE_W-1:0]   rd_data;

   // the held item moves on when the result register is free or draining
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= req_tuser[1:0];
         in_data_ff  <= req_tdata;
         in_first_ff <= req_tuser[2];
         in_last_ff  <= req_tlast;
      end
      if (fire) begin
         out_res_ff <= result;
      end
   end

   rs485ftx_ctrl #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_fire   (fire),
      .item_op     (in_op_ff),
      .item_first  (in_first_ff),
      .item_last   (in_last_ff),
      .result      (result),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr)
   );

   // frame store, read latched alongside the result register
   rs485ftx_store #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_data_ff),
      .rd_en   (fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.tx_valid;
   // filler characters and idle steps report a zero byte
   assign rsp_tdata[7:0]   = out_res_ff.use_mem ? rd_data : '0;
   assign rsp_tdata[8]     = out_res_ff.driver_enable;
   assign rsp_tdata[9]     = out_res_ff.receiver_enable;
   assign rsp_tdata[10]    = out_res_ff.frame_done;
   assign rsp_tdata[12:11] = out_res_ff.phase;
   assign rsp_tdata[15:13] = '0;

endmodule

`default_nettype wire

// File: tb/tb_rs485_frame_transmit_sequencer_core.sv
`default_nettype none

module tb_rs485_frame_transmit_sequencer_core;

   localparam int STORE_DEPTH = rs485ftx_pkg::FRAME_BYTES_DEF;
   localparam logic [rs485ftx_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [rs485ftx_pkg::OP_W-1:0]   op;
      logic [rs485ftx_pkg::BYTE_W-1:0] data;
      logic                            first;
      logic                            last;
   } req_item_type;

   typedef struct packed {
      logic                            tx_valid;
      logic [rs485ftx_pkg::BYTE_W-1:0] tx_byte;
      logic                            driver_enable;
      logic                            receiver_enable;
      logic                            frame_done;
      rs485ftx_pkg::phase_type         phase;
   } tx_result_type;

   typedef struct {
      req_item_type  item;
      bit            typed;
      tx_result_type want;
   } dir_row_type;

   localparam tx_result_type RESULT_IDLE = '{tx_valid: 1'b0, tx_byte: 8'h00,
      driver_enable: 1'b0, receiver_enable: 1'b1, frame_done: 1'b0,
      phase: rs485ftx_pkg::PH_IDLE};
   localparam tx_result_type RESULT_FIRST_SENT = '{tx_valid: 1'b1, tx_byte: 8'h00,
      driver_enable: 1'b1, receiver_enable: 1'b0, frame_done: 1'b0,
      phase: rs485ftx_pkg::PH_DATA};

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [rs485ftx_pkg::FILL_W-1:0] csr_wr_data;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // data[7:0]
   logic [2:0]                      req_tuser;   // op[1:0], first[2]
   logic                            req_tlast;   // last
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [15:0]                     rsp_tdata;   // tx_byte[7:0], driver_enable[8],
                                                 // receiver_enable[9], frame_done[10],
                                                 // phase[12:11], zero pad[15:13]
   logic                            rsp_tuser;   // tx_valid

   rs485_frame_transmit_sequencer_core #(
      .FRAME_BYTES (STORE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   // sequencer state as the block should hold it
   logic [rs485ftx_pkg::BYTE_W-1:0] line_store [STORE_DEPTH];
   int                              line_len = 0;
   int                              send_pos = 0;
   rs485ftx_pkg::phase_type         seq_phase = rs485ftx_pkg::PH_IDLE;
   bit                              start_armed = 1'b0;
   logic [rs485ftx_pkg::FILL_W-1:0] fill_left = '0;
   bit                              drive_on = 1'b0;
   logic [rs485ftx_pkg::FILL_W-1:0] postdrive_setting = rs485ftx_pkg::POSTDRIVE_RESET;

   tx_result_type tx_expected [$];
   int            mismatch_count = 0;
   int            transfers_checked = 0;
   int            items_sent = 0;
   int            calm_left = 0;

   dir_row_type directed_table [25];

   function automatic tx_result_type advance_sequencer(input req_item_type it);
      tx_result_type r;
      r = '0;
      case (it.op)
         rs485ftx_pkg::OP_LOAD: begin
            if (it.first) begin
               // restart aborts data and completion phases, never filler
               if (seq_phase == rs485ftx_pkg::PH_DATA || seq_phase == rs485ftx_pkg::PH_WAIT)
                  seq_phase = rs485ftx_pkg::PH_IDLE;
               line_len = 0;
            end
            if (line_len < STORE_DEPTH) begin
               line_store[line_len] = it.data;
               line_len++;
            end
            if (it.last)
               start_armed = 1'b1;
         end
         rs485ftx_pkg::OP_START: begin
            if (start_armed && seq_phase == rs485ftx_pkg::PH_IDLE) begin
               drive_on = 1'b1;
               seq_phase = rs485ftx_pkg::PH_DATA;
               send_pos = 0;
               start_armed = 1'b0;
               r.tx_valid = 1'b1;
               r.tx_byte = line_store[0];
            end
         end
         rs485ftx_pkg::OP_CHAR_DONE: begin
            case (seq_phase)
               rs485ftx_pkg::PH_DATA: begin
                  send_pos++;
                  if (send_pos < line_len) begin
                     r.tx_valid = 1'b1;
                     r.tx_byte = line_store[send_pos];
                  end else begin
                     // driver released, first zero filler goes out now
                     drive_on = 1'b0;
                     fill_left = postdrive_setting;
                     seq_phase = rs485ftx_pkg::PH_FILL;
                     r.tx_valid = 1'b1;
                  end
               end
               rs485ftx_pkg::PH_FILL: begin
                  if (fill_left != '0) begin
                     fill_left--;
                     if (fill_left == '0)
                        seq_phase = rs485ftx_pkg::PH_WAIT;
                     r.tx_valid = 1'b1;
                  end else begin
                     seq_phase = rs485ftx_pkg::PH_WAIT;
                  end
               end
               rs485ftx_pkg::PH_WAIT: begin
                  seq_phase = rs485ftx_pkg::PH_IDLE;
                  r.frame_done = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.driver_enable = drive_on;
      r.receiver_enable = (seq_phase == rs485ftx_pkg::PH_IDLE) && !drive_on;
      r.phase = seq_phase;
      return r;
   endfunction

   function automatic req_item_type stim(input logic [rs485ftx_pkg::OP_W-1:0] op,
                                         input logic [7:0] data,
                                         input logic first, input logic last);
      req_item_type it;
      it.op = op;
      it.data = data;
      it.first = first;
      it.last = last;
      return it;
   endfunction

   // mostly back to back, some short gaps, now and then a long one
   function automatic int sender_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(20, 60);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch at transfer %0d: %s got 0x%0h, want 0x%0h",
                  transfers_checked, what, got, want);
   endtask

   // offer one item and wait for its transfer; the prediction is made on acceptance
   task automatic push_req(input req_item_type it, input bit typed = 1'b0,
                           input tx_result_type want = '0);
      int            gap;
      tx_result_type predicted;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= it.data;
      req_tuser <= {it.first, it.op};
      req_tlast <= it.last;
      do @(posedge clock); while (!req_tready);
      predicted = advance_sequencer(it);
      tx_expected.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 11) == 0)
         push_req(stim(2'($urandom_range(0, 3)), 8'($urandom),
                       $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1))));
   endtask

   // load a frame, start it and report character completions to the end,
   // with stray items and the odd broken mark or miscounted event
   task automatic send_frame(input int n);
      req_item_type it;
      int           dones;
      int           stored;
      for (int i = 0; i < n; i++) begin
         it = stim(rs485ftx_pkg::OP_LOAD, 8'($urandom), i == 0, i == n - 1);
         if ($urandom_range(0, 39) == 0) it.last = ~it.last;
         if ($urandom_range(0, 49) == 0) it.first = ~it.first;
         push_req(it);
         maybe_noise();
      end
      push_req(stim(rs485ftx_pkg::OP_START, 8'($urandom), 1'b0, 1'b0));
      maybe_noise();
      stored = (n > STORE_DEPTH) ? STORE_DEPTH : n;
      dones = stored + ((postdrive_setting == '0) ? 1 : int'(postdrive_setting)) + 1;
      if ($urandom_range(0, 9) == 0)
         dones = dones - $urandom_range(1, 3);
      else if ($urandom_range(0, 9) == 0)
         dones = dones + $urandom_range(1, 3);
      for (int i = 0; i < dones; i++) begin
         push_req(stim(rs485ftx_pkg::OP_CHAR_DONE, 8'($urandom),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         maybe_noise();
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tx_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_postdrive(input logic [rs485ftx_pkg::FILL_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      postdrive_setting = v;
   endtask

   // result side: compare each transfer with the oldest prediction
   always @(posedge clock) begin : rsp_check
      tx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tx_expected.size() == 0) begin
            report_mismatch("transfer with nothing expected", int'(rsp_tdata), 0);
         end else begin
            want = tx_expected.pop_front();
            if (rsp_tuser !== want.tx_valid)
               report_mismatch("tx_valid", int'(rsp_tuser), int'(want.tx_valid));
            if (rsp_tdata[7:0] !== want.tx_byte)
               report_mismatch("tx_byte", int'(rsp_tdata[7:0]), int'(want.tx_byte));
            if (rsp_tdata[8] !== want.driver_enable)
               report_mismatch("driver_enable", int'(rsp_tdata[8]),
                               int'(want.driver_enable));
            if (rsp_tdata[9] !== want.receiver_enable)
               report_mismatch("receiver_enable", int'(rsp_tdata[9]),
                               int'(want.receiver_enable));
            if (rsp_tdata[10] !== want.frame_done)
               report_mismatch("frame_done", int'(rsp_tdata[10]), int'(want.frame_done));
            if (rsp_tdata[12:11] !== want.phase)
               report_mismatch("phase", int'(rsp_tdata[12:11]), int'(want.phase));
         end
         transfers_checked++;
      end
   end

   // receiver back-pressure, with one long hold so the block fills up
   initial begin : rsp_pacing
      int  r;
      bit  held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && transfers_checked >= 150) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            for (int k = 0; k < 120; k++) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else if (r < 95) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [rs485ftx_pkg::FILL_W-1:0] settings [4];
      int                              target;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= rs485ftx_pkg::POSTDRIVE_RESET;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      req_tlast <= 1'b0;

      directed_table = '{
         // events with nothing loaded, unknown op
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b1, RESULT_IDLE},
         '{stim(rs485ftx_pkg::OP_START,     8'h00, 1'b0, 1'b0), 1'b1, RESULT_IDLE},
         '{stim(OP_UNUSED,                  8'hff, 1'b1, 1'b1), 1'b1, RESULT_IDLE},
         // two-byte frame at the byte extremes, sent with the reset filler count
         '{stim(rs485ftx_pkg::OP_LOAD,      8'h00, 1'b1, 1'b0), 1'b1, RESULT_IDLE},
         '{stim(rs485ftx_pkg::OP_LOAD,      8'hff, 1'b0, 1'b1), 1'b1, RESULT_IDLE},
         '{stim(rs485ftx_pkg::OP_START,     8'h00, 1'b0, 1'b0), 1'b1, RESULT_FIRST_SENT},
         '{stim(rs485ftx_pkg::OP_START,     8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         // append while the frame is on the line
         '{stim(rs485ftx_pkg::OP_LOAD,      8'ha5, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         // new frame during filler does not abort
         '{stim(rs485ftx_pkg::OP_LOAD,      8'h3c, 1'b1, 1'b1), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_START,     8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_START,     8'h00, 1'b0, 1'b0), 1'b0, '0},
         // abort in the data phase, driver left on
         '{stim(rs485ftx_pkg::OP_LOAD,      8'h81, 1'b1, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_LOAD,      8'h7e, 1'b0, 1'b1), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_START,     8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         '{stim(rs485ftx_pkg::OP_CHAR_DONE, 8'h00, 1'b0, 1'b0), 1'b0, '0},
         // abort while waiting for completion
         '{stim(rs485ftx_pkg::OP_LOAD,      8'h42, 1'b1, 1'b1), 1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i])
         push_req(directed_table[i].item, directed_table[i].typed, directed_table[i].want);

      // filler count extremes first, then two in between
      settings[0] = 4'd0;
      settings[1] = 4'd15;
      settings[2] = 4'd1;
      settings[3] = 4'($urandom_range(3, 14));
      foreach (settings[p]) begin
         wait_idle();
         write_postdrive(settings[p]);
         target = items_sent + 260;
         // one frame past the store size, so the tail bytes are dropped
         if (p == 2)
            send_frame(STORE_DEPTH + 3);
         while (items_sent < target)
            send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && tx_expected.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
